/* sv/dq_pkg.sv */
// dq_pkg: shared constants, operation and status codes, and the cell control
// type for the deque core. No dependencies.
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 3;
  localparam int STAT_W    = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic shift_in;   // push at front: take the left neighbour's word
    logic shift_out;  // pop at front: take the right neighbour's word
    logic snap;       // copy the stored word into the read-back stage
    logic walk;       // move the read-back stage one cell towards the front
  } dq_cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/dq_cell.sv */
// dq_cell: one slot of the deque row, a stored word and a read-back stage.
// Depends on dq_pkg.
`default_nettype none

module dq_cell
  import dq_pkg::*;
(
  input  wire logic              clk,
  input  wire dq_cell_ctrl_t     ctrl,
  input  wire logic              wr_en,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  input  wire logic [DATA_W-1:0] right_ret,
  output logic      [DATA_W-1:0] data,
  output logic      [DATA_W-1:0] ret
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [DATA_W-1:0] ret_r;
  logic [DATA_W-1:0] ret_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_in) begin
      data_nxt = left_data;
    end else if (ctrl.shift_out) begin
      data_nxt = right_data;
    end else if (wr_en) begin
      data_nxt = wr_data;
    end
  end

  always_comb begin
    ret_nxt = ret_r;
    if (ctrl.snap) begin
      ret_nxt = data_r;
    end else if (ctrl.walk) begin
      ret_nxt = right_ret;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    ret_r  <= ret_nxt;
  end

  assign data = data_r;
  assign ret  = ret_r;

endmodule

`default_nettype wire

/* sv/double_ended_queue_core.sv */
// double_ended_queue_core: bounded deque of signed words held in a row of cells.
// Depends on dq_pkg and dq_cell.
`default_nettype none

// The front element always sits in cell 0 and the elements fill the row in
// order, so a push at the front shifts the whole row one cell back and a pop
// at the front shifts it one cell forward; a push at the back writes the cell
// at the element count. Clear, both pushes and a pop at the front need no
// walk: while busy is low an item may follow every cycle and its result is
// strobed on out_valid in the next cycle. A pop at the back copies the row
// into the read-back stages and walks them towards cell 0, so busy stays
// high until the back word reaches cell 0, and the result comes with busy
// falling; refused items (full or empty) come in the next cycle. Results
// are shown for a single cycle and cannot be held off by the receiver.
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CntW = $clog2(DEPTH + 1),
  localparam int IdxW = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [MODE_W-1:0] in_mode,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed      [DATA_W-1:0] out_popped_value,
  output logic             [STAT_W-1:0] out_status,
  output logic             [CntW-1:0]   out_element_count,
  output logic             [CntW-1:0]   out_even_count
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic              state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [CntW-1:0]   evn_r, evn_nxt;
  logic [IdxW-1:0]   walk_r, walk_nxt;
  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] pop_r, pop_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  dq_cell_ctrl_t     ctrl;
  logic              push_back_go;
  logic              accept;
  logic              full;
  logic              empty;
  logic [CntW-1:0]   cnt_dec;
  logic [CntW-1:0]   evn_dec_front;
  logic [CntW-1:0]   evn_dec_back;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_ret  [DEPTH];

  assign accept  = start && (state_r == ST_IDLE);
  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign cnt_dec = cnt_r - CntW'(1);

  // Drop one even only if the leaving word is even
  assign evn_dec_front = (!cell_data[0][0] && (evn_r != '0)) ? evn_r - CntW'(1) : evn_r;
  assign evn_dec_back  = (!cell_ret[0][0]  && (evn_r != '0)) ? evn_r - CntW'(1) : evn_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    evn_nxt      = evn_r;
    walk_nxt     = walk_r;
    valid_nxt    = 1'b0;
    pop_nxt      = '0;
    stat_nxt     = STAT_DONE;
    ctrl         = '0;
    push_back_go = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          valid_nxt = 1'b1;
          unique case (in_mode) inside
            MODE_CLEAR: begin
              cnt_nxt = '0;
              evn_nxt = '0;
            end
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (full) begin
                stat_nxt = STAT_FULL;
              end else begin
                cnt_nxt = cnt_r + CntW'(1);
                evn_nxt = evn_r + CntW'(!in_value[0]);
                if (in_mode == MODE_PUSH_FRONT) begin
                  ctrl.shift_in = 1'b1;
                end else begin
                  push_back_go = 1'b1;
                end
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                stat_nxt = STAT_EMPTY;
              end else begin
                pop_nxt        = cell_data[0];
                cnt_nxt        = cnt_dec;
                evn_nxt        = evn_dec_front;
                ctrl.shift_out = 1'b1;
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                stat_nxt = STAT_EMPTY;
              end else begin
                // Hold the result until the back word reaches cell 0
                valid_nxt = 1'b0;
                ctrl.snap = 1'b1;
                walk_nxt  = cnt_dec[IdxW-1:0];
                state_nxt = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_r == '0) begin
          valid_nxt = 1'b1;
          pop_nxt   = cell_ret[0];
          cnt_nxt   = cnt_dec;
          evn_nxt   = evn_dec_back;
          state_nxt = ST_IDLE;
        end else begin
          ctrl.walk = 1'b1;
          walk_nxt  = walk_r - IdxW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    logic [DATA_W-1:0] right_r;

    if (i == 0) begin : g_head
      assign left_d = in_value;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
      assign right_r = '0;
    end else begin : g_body
      assign right_d = cell_data[i+1];
      assign right_r = cell_ret[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_en      (push_back_go && (cnt_r == CntW'(i))),
      .wr_data    (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .right_ret  (right_r),
      .data       (cell_data[i]),
      .ret        (cell_ret[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      evn_r   <= '0;
      walk_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      evn_r   <= evn_nxt;
      walk_r  <= walk_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_r  <= pop_nxt;
    stat_r <= stat_nxt;
  end

  assign busy              = (state_r == ST_WALK);
  assign out_valid         = valid_r;
  assign out_popped_value  = signed'(pop_r);
  assign out_status        = stat_r;
  assign out_element_count = cnt_r;
  assign out_even_count    = evn_r;

endmodule

`default_nettype wire

/* sv/dq_checker.sv */
// dq_checker: port-level assertions for double_ended_queue_core, with its bind.
// Depends on dq_pkg.
`default_nettype none

module dq_checker
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [CntW-1:0]   out_element_count,
  input wire logic [CntW-1:0]   out_even_count
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("beat or busy right after reset");

  a_even_le_count: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_even_count <= out_element_count)
    else $error("even count above element count");

  a_full_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_status == STAT_FULL) |-> out_element_count == CntW'(DEPTH))
    else $error("push refused below full");

  a_empty_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_status == STAT_EMPTY) |-> out_element_count == '0)
    else $error("pop refused while not empty");

  a_back_pop_ends: assert property (@(posedge clk) disable iff (!rst_n)
      $fell(busy) |-> out_valid)
    else $error("back pop finished without a beat");

endmodule

bind double_ended_queue_core dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_element_count (out_element_count),
  .out_even_count    (out_even_count)
);

`default_nettype wire
